// ===== sv/multilevel_queue_slot_scheduler_defines.svh =====
// assertion macros shared by the scheduler modules
`ifndef MULTILEVEL_QUEUE_SLOT_SCHEDULER_DEFINES_SVH
`define MULTILEVEL_QUEUE_SLOT_SCHEDULER_DEFINES_SVH

// same-cycle implication, checked at every rising clock edge out of reset
`define MLQS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mlqs assertion failed");

// next-cycle implication
`define MLQS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mlqs assertion failed");

`endif

// ===== sv/mlqs_pkg.sv =====
// types, constants and helper functions of the multilevel queue scheduler
`timescale 1ns / 1ps

package mlqs_pkg;

   localparam int LEVELS      = 8;
   localparam int QUEUE_DEPTH = 16;

   localparam int ID_W      = 8;
   localparam int PRIO_W    = 3;
   localparam int OUT_LVL_W = 3;

   localparam int LVL_W  = $clog2(LEVELS);
   localparam int HEAD_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int BUD_W  = $clog2(LEVELS + 1);
   localparam int ADDR_W = $clog2(LEVELS * QUEUE_DEPTH);

   localparam logic MODE_ENQUEUE = 1'b0;
   localparam logic MODE_REQUEST = 1'b1;

   typedef struct packed {
      logic              mode;
      logic [ID_W-1:0]   proc_id;
      logic [PRIO_W-1:0] priority_req;
   } req_payload_type;

   typedef struct packed {
      logic [ID_W-1:0]      granted_id;
      logic                 granted;
      logic [OUT_LVL_W-1:0] served_level;
      logic                 rejected;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SELECT,
      ST_ACCESS,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic latch;
      logic select;
      logic access;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic             found;
      logic [LVL_W-1:0] level;
   } search_result_type;

   // first eligible level after cur, cyclic, cur itself excluded
   function automatic search_result_type find_next(input logic [LEVELS-1:0] elig,
                                                   input logic [LVL_W-1:0]  cur);
      search_result_type res;
      logic [LVL_W:0]    idx;
      res.found = 1'b0;
      res.level = cur;
      // walk from farthest to nearest so the nearest hit wins
      for (int k = LEVELS - 1; k >= 1; k--) begin
         idx = {1'b0, cur} + (LVL_W + 1)'(k);
         if (idx >= (LVL_W + 1)'(LEVELS)) begin
            idx = idx - (LVL_W + 1)'(LEVELS);
         end
         if (elig[idx[LVL_W-1:0]]) begin
            res.found = 1'b1;
            res.level = idx[LVL_W-1:0];
         end
      end
      return res;
   endfunction

endpackage

// ===== sv/mlqs_ctrl.sv =====
// controller state machine: sequences select, queue access and result load
`timescale 1ns / 1ps
`include "multilevel_queue_slot_scheduler_defines.svh"

module mlqs_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mlqs_pkg::cmd_type cmd
);

   mlqs_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mlqs_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd.latch  = 1'b0;
      cmd.select = 1'b0;
      cmd.access = 1'b0;
      cmd.load   = 1'b0;
      unique case (state_ff)
         mlqs_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = mlqs_pkg::ST_SELECT;
            end
         end
         mlqs_pkg::ST_SELECT: begin
            cmd.select = 1'b1;
            state_in   = mlqs_pkg::ST_ACCESS;
         end
         mlqs_pkg::ST_ACCESS: begin
            cmd.access = 1'b1;
            state_in   = mlqs_pkg::ST_DONE;
         end
         mlqs_pkg::ST_DONE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load = 1'b1;
               state_in = mlqs_pkg::ST_IDLE;
            end
         end
         default: state_in = mlqs_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   assign req_stall = (state_ff != mlqs_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `MLQS_ASSERT_NEXT(a_load_sets_valid, clock, reset, cmd.load, rsp_valid_ff)
   `MLQS_ASSERT_NEXT(a_accept_starts_select, clock, reset, req_valid && !req_stall,
                     state_ff == mlqs_pkg::ST_SELECT && !cmd.load)
   `MLQS_ASSERT_NEXT(a_stalled_rsp_holds, clock, reset, rsp_valid_ff && rsp_stall, rsp_valid_ff)

endmodule

// ===== sv/mlqs_datapath.sv =====
// datapath: level fifo bookkeeping, slot budgets, cyclic level search, id memory
`timescale 1ns / 1ps
`include "multilevel_queue_slot_scheduler_defines.svh"

module mlqs_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  mlqs_pkg::cmd_type        cmd,
   input  mlqs_pkg::req_payload_type req_data,
   output mlqs_pkg::rsp_payload_type rsp_data
);

   mlqs_pkg::req_payload_type item_ff;
   mlqs_pkg::rsp_payload_type rsp_ff, rsp_in;

   logic [mlqs_pkg::HEAD_W-1:0] head_ff   [mlqs_pkg::LEVELS];
   logic [mlqs_pkg::CNT_W-1:0]  count_ff  [mlqs_pkg::LEVELS];
   logic [mlqs_pkg::BUD_W-1:0]  budget_ff [mlqs_pkg::LEVELS];
   logic [mlqs_pkg::LVL_W-1:0]  cur_ff;

   logic [mlqs_pkg::LVL_W-1:0]  level_sel_ff, level_sel_in;
   logic                        go_ff, go_in;
   logic                        refill;

   logic [mlqs_pkg::ID_W-1:0]   mem [mlqs_pkg::LEVELS * mlqs_pkg::QUEUE_DEPTH];
   logic [mlqs_pkg::ID_W-1:0]   rd_data_ff;

   logic [mlqs_pkg::LEVELS-1:0] nonempty, budget_nz, full, elig;
   logic                        counts_ok;
   logic                        prio_ok;
   logic [mlqs_pkg::LVL_W-1:0]  prio_lvl;
   mlqs_pkg::search_result_type srch;

   logic [mlqs_pkg::HEAD_W-1:0] sel_head, head_next, tail, slot_idx;
   logic [mlqs_pkg::CNT_W-1:0]  sel_count;
   logic [mlqs_pkg::CNT_W:0]    tail_sum;
   logic [mlqs_pkg::ADDR_W-1:0] mem_addr;
   logic                        is_enq;

   // per-level flags, each read at its own level
   always_comb begin
      counts_ok = 1'b1;
      for (int i = 0; i < mlqs_pkg::LEVELS; i++) begin
         nonempty[i]  = (count_ff[i] != '0);
         budget_nz[i] = (budget_ff[i] != '0);
         full[i]      = (count_ff[i] >= mlqs_pkg::CNT_W'(mlqs_pkg::QUEUE_DEPTH));
         elig[i]      = nonempty[i] && budget_nz[i];
         if (count_ff[i] > mlqs_pkg::CNT_W'(mlqs_pkg::QUEUE_DEPTH)) begin
            counts_ok = 1'b0;
         end
      end
   end

   assign is_enq   = (item_ff.mode == mlqs_pkg::MODE_ENQUEUE);
   assign prio_ok  = (32'(item_ff.priority_req) < 32'(mlqs_pkg::LEVELS));
   assign prio_lvl = mlqs_pkg::LVL_W'(item_ff.priority_req);
   assign srch     = mlqs_pkg::find_next(elig, cur_ff);

   // level decision
   always_comb begin
      level_sel_in = cur_ff;
      go_in        = 1'b0;
      refill       = 1'b0;
      if (is_enq) begin
         level_sel_in = prio_lvl;
         go_in        = prio_ok && !full[prio_lvl];
      end else if (budget_nz[cur_ff] && nonempty[cur_ff]) begin
         level_sel_in = cur_ff;
         go_in        = 1'b1;
      end else begin
         // spent budget is refilled, the current level is skipped either way
         refill       = !budget_nz[cur_ff];
         level_sel_in = srch.level;
         go_in        = srch.found;
      end
   end

   // fifo indexes of the selected level
   always_comb begin
      sel_head  = head_ff[level_sel_ff];
      sel_count = count_ff[level_sel_ff];
      tail_sum  = (mlqs_pkg::CNT_W + 1)'(sel_head) + (mlqs_pkg::CNT_W + 1)'(sel_count);
      if (tail_sum >= (mlqs_pkg::CNT_W + 1)'(mlqs_pkg::QUEUE_DEPTH)) begin
         tail_sum = tail_sum - (mlqs_pkg::CNT_W + 1)'(mlqs_pkg::QUEUE_DEPTH);
      end
      tail = mlqs_pkg::HEAD_W'(tail_sum);
      if (sel_head == mlqs_pkg::HEAD_W'(mlqs_pkg::QUEUE_DEPTH - 1)) begin
         head_next = '0;
      end else begin
         head_next = sel_head + 1'b1;
      end
      slot_idx = is_enq ? tail : sel_head;
      mem_addr = mlqs_pkg::ADDR_W'(32'(level_sel_ff) * mlqs_pkg::QUEUE_DEPTH)
               + mlqs_pkg::ADDR_W'(slot_idx);
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         item_ff <= req_data;
      end
      if (cmd.select) begin
         level_sel_ff <= level_sel_in;
         go_ff        <= go_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mlqs_pkg::LEVELS; i++) begin
            head_ff[i]   <= '0;
            count_ff[i]  <= '0;
            budget_ff[i] <= mlqs_pkg::BUD_W'(mlqs_pkg::LEVELS - i);
         end
         cur_ff <= '0;
      end else begin
         if (cmd.select && refill) begin
            budget_ff[cur_ff] <= mlqs_pkg::BUD_W'(mlqs_pkg::LEVELS - int'(cur_ff));
         end
         if (cmd.access && go_ff) begin
            if (is_enq) begin
               count_ff[level_sel_ff] <= sel_count + 1'b1;
            end else begin
               head_ff[level_sel_ff]   <= head_next;
               count_ff[level_sel_ff]  <= sel_count - 1'b1;
               budget_ff[level_sel_ff] <= budget_ff[level_sel_ff] - 1'b1;
               cur_ff                  <= level_sel_ff;
            end
         end
      end
   end

   // process id store, one access per item
   always_ff @(posedge clock) begin
      if (cmd.access && go_ff && is_enq) begin
         mem[mem_addr] <= item_ff.proc_id;
      end
      if (cmd.access && go_ff && !is_enq) begin
         rd_data_ff <= mem[mem_addr];
      end
   end

   always_comb begin
      rsp_in.granted      = !is_enq && go_ff;
      rsp_in.granted_id   = rsp_in.granted ? rd_data_ff : '0;
      rsp_in.served_level = mlqs_pkg::OUT_LVL_W'(cur_ff);
      rsp_in.rejected     = is_enq && !go_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

   `MLQS_ASSERT_NOW(a_counts_in_range, clock, reset, 1'b1, counts_ok)
   `MLQS_ASSERT_NEXT(a_pop_moves_current, clock, reset, cmd.access && go_ff && !is_enq,
                     cur_ff == $past(level_sel_ff))
   `MLQS_ASSERT_NEXT(a_refill_restores_budget, clock, reset, cmd.select && refill,
                     budget_ff[$past(cur_ff)] != '0)

endmodule

// ===== sv/multilevel_queue_slot_scheduler.sv =====
// top level of the multilevel ready-queue slot scheduler
//
//   channel   direction   handshake              beat
//   req_      in          req_valid / req_stall  mlqs_pkg::req_payload_type
//   rsp_      out         rsp_valid / rsp_stall  mlqs_pkg::rsp_payload_type
//
// one beat at a time: the controller steps through select, queue access (with the
// memory read) and done states, and the result register is loaded from the done
// state once rsp is free; req_stall holds off the next request beat until idle.
// the result register lets a new request in while the last result is stalled.
// synchronous reset empties all level queues and restores budgets; no clearing pass.
`timescale 1ns / 1ps

module multilevel_queue_slot_scheduler (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  mlqs_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output mlqs_pkg::rsp_payload_type rsp_data
);

   mlqs_pkg::cmd_type cmd;

   mlqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   mlqs_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule
